@@ rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
package bba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int BLOCK_W    = 12;
    localparam int TOTAL_W    = 13;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(4096);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = TOTAL_W'(MAX_BLOCKS);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_OUT_OF_BLOCKS = 2'd1;
    localparam logic [1:0] ST_DOUBLE_FREE   = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE  = 2'd3;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic               en;
        logic [WORD_AW-1:0] addr;
        t_word              data;
    } t_ram_wr;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] bit_idx;
    } t_scan_res;

    function automatic t_word bit_mask(input logic [BIT_AW-1:0] b);
        t_word m;
        m = '0;
        m[b] = 1'b1;
        return m;
    endfunction

endpackage

@@ rtl/bba_bitmap_ram.sv @@
`timescale 1ns / 1ps
module bba_bitmap_ram
    import bba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [WORD_AW-1:0] i_rd_addr,
    output t_word              o_rd_data,
    input  t_ram_wr            i_wr
);

    t_word             r_mem [WORDS];
    logic [WORDS-1:0]  r_valid;
    t_word             r_rd_data;

    // a row never written since reset reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/bba_scan_unit.sv @@
`timescale 1ns / 1ps
module bba_scan_unit
    import bba_pkg::*;
(
    input  t_word             i_word,
    input  logic              i_is_last,
    input  logic [BIT_AW-1:0] i_last_bit,
    output t_scan_res         o_res
);

    t_word w_free;

    // keep only free bits below the limit, then pick the lowest one
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_free[b] = !i_word[b] && (!i_is_last || (BIT_AW'(b) <= i_last_bit));
        end
    end

    always_comb begin
        o_res.found   = |w_free;
        o_res.bit_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                o_res.bit_idx = BIT_AW'(b);
            end
        end
    end

endmodule

@@ rtl/bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
// First-fit block allocator over a 4096-block in-use bitmap (128 words of 32 bits).
// Command channel: drive i_func / i_block_number with start; the item is taken
// on a clock edge where start is high and busy is low. i_func 0 allocates the
// lowest free block below total_blocks, i_func 1 frees i_block_number.
// Result channel: o_done is high for exactly one cycle with o_granted_block and
// o_status; the receiver cannot stall and must take it in that cycle.
// Config: i_cfg_we writes total_blocks from i_cfg_wdata; write only while idle.
// Operation: an allocate reads one bitmap word per cycle through the single read
// port and tests it in the scan unit, stopping at the first word with a free
// block below the limit. A free reads the word, then tests the bit and, if the
// block was in use, writes the word back with the bit cleared. Requests that
// fail the range check answer in the cycle after they are taken.
// One item is in flight at a time; busy stays high until the result is issued.
// Reset (synchronous, active low) marks every block free at once through per
// word valid bits and sets total_blocks to 4096; no clearing pass is needed.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic [BLOCK_W-1:0] i_block_number,
    input  logic               i_cfg_we,
    input  logic [TOTAL_W-1:0] i_cfg_wdata,
    output logic               o_done,
    output logic [BLOCK_W-1:0] o_granted_block,
    output logic [1:0]         o_status
);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_SCAN     = 2'd1;
    localparam logic [1:0] S_FREE_CHK = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [TOTAL_W-1:0] r_total;
    logic [WORD_AW-1:0] r_word, n_word;
    logic               r_issue, n_issue;
    logic               r_pend, n_pend;
    logic [WORD_AW-1:0] r_chk_word, n_chk_word;
    logic [WORD_AW-1:0] r_last_word, n_last_word;
    logic [BIT_AW-1:0]  r_last_bit, n_last_bit;
    logic [BLOCK_W-1:0] r_bn, n_bn;
    logic               r_done, n_done;
    logic [BLOCK_W-1:0] r_granted, n_granted;
    logic [1:0]         r_status, n_status;

    logic [TOTAL_W-1:0] w_lim;
    logic [TOTAL_W-1:0] w_lim_m1;
    logic               w_rd_en;
    logic [WORD_AW-1:0] w_rd_addr;
    t_word              w_rd_data;
    t_ram_wr            w_wr;
    t_scan_res          w_scan;

    assign w_lim    = (r_total > TOTAL_MAX) ? TOTAL_MAX : r_total;
    assign w_lim_m1 = w_lim - TOTAL_W'(1);

    bba_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr      (w_wr)
    );

    bba_scan_unit u_scan (
        .i_word     (w_rd_data),
        .i_is_last  (r_chk_word == r_last_word),
        .i_last_bit (r_last_bit),
        .o_res      (w_scan)
    );

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_issue     = r_issue;
        n_pend      = 1'b0;
        n_chk_word  = r_chk_word;
        n_last_word = r_last_word;
        n_last_bit  = r_last_bit;
        n_bn        = r_bn;
        n_done      = 1'b0;
        n_granted   = r_granted;
        n_status    = r_status;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_word;
        w_wr.en     = 1'b0;
        w_wr.addr   = r_chk_word;
        w_wr.data   = w_rd_data;

        case (r_state)
            S_IDLE: begin
                w_rd_addr = i_block_number[BLOCK_W-1:BIT_AW];
                if (start) begin
                    n_granted = '0;
                    if (i_func == FUNC_ALLOC) begin
                        if (w_lim == '0) begin
                            n_done   = 1'b1;
                            n_status = ST_OUT_OF_BLOCKS;
                        end else begin
                            n_state     = S_SCAN;
                            n_word      = '0;
                            n_issue     = 1'b1;
                            n_last_word = w_lim_m1[BLOCK_W-1:BIT_AW];
                            n_last_bit  = w_lim_m1[BIT_AW-1:0];
                        end
                    end else begin
                        if (TOTAL_W'(i_block_number) >= w_lim) begin
                            n_done   = 1'b1;
                            n_status = ST_OUT_OF_RANGE;
                        end else begin
                            w_rd_en = 1'b1;
                            n_bn    = i_block_number;
                            n_state = S_FREE_CHK;
                        end
                    end
                end
            end

            S_SCAN: begin
                // read one word per cycle while testing the word read last cycle
                w_rd_en    = r_issue;
                n_pend     = r_issue;
                n_chk_word = r_word;
                if (r_issue) begin
                    if (r_word == r_last_word) begin
                        n_issue = 1'b0;
                    end else begin
                        n_word = r_word + WORD_AW'(1);
                    end
                end
                if (r_pend) begin
                    if (w_scan.found) begin
                        w_wr.en   = 1'b1;
                        w_wr.data = w_rd_data | bit_mask(w_scan.bit_idx);
                        n_granted = {r_chk_word, w_scan.bit_idx};
                        n_status  = ST_OK;
                        n_done    = 1'b1;
                        n_issue   = 1'b0;
                        n_pend    = 1'b0;
                        n_state   = S_IDLE;
                    end else if (r_chk_word == r_last_word) begin
                        n_status = ST_OUT_OF_BLOCKS;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end

            S_FREE_CHK: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (!w_rd_data[r_bn[BIT_AW-1:0]]) begin
                    n_status = ST_DOUBLE_FREE;
                end else begin
                    w_wr.en   = 1'b1;
                    w_wr.addr = r_bn[BLOCK_W-1:BIT_AW];
                    w_wr.data = w_rd_data & ~bit_mask(r_bn[BIT_AW-1:0]);
                    n_status  = ST_OK;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_total <= TOTAL_RESET;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_pend  <= n_pend;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word      <= n_word;
        r_chk_word  <= n_chk_word;
        r_last_word <= n_last_word;
        r_last_bit  <= n_last_bit;
        r_bn        <= n_bn;
        r_granted   <= n_granted;
        r_status    <= n_status;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_granted_block = r_granted;
    assign o_status        = r_status;

endmodule

@@ rtl/bba_checker.sv @@
`timescale 1ns / 1ps
module bba_checker
    import bba_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_func,
    input logic [BLOCK_W-1:0] i_block_number,
    input logic               i_cfg_we,
    input logic [TOTAL_W-1:0] i_cfg_wdata,
    input logic               o_done,
    input logic [BLOCK_W-1:0] o_granted_block,
    input logic [1:0]         o_status
);

    // a result only follows an accepted item or a busy period
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without an item in flight");

    // an accepted item either answers at once or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item dropped");

    a_no_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result issued while still busy");

    a_err_zero_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_granted_block == '0))
        else $error("failed request returned a nonzero block");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import bba_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 56;
    localparam int PHASES         = 8;

    typedef struct {
        logic [BLOCK_W-1:0] block;
        logic [1:0]         status;
    } grant_t;

    class alloc_scoreboard;
        bit [MAX_BLOCKS-1:0] in_use;
        logic [TOTAL_W-1:0]  total_blocks;
        grant_t              pending_grants[$];
        int                  errors;
        int                  checked;
        int                  status_seen[4];
        int                  alloc_count;
        int                  free_count;

        function new();
            in_use       = '0;
            total_blocks = TOTAL_RESET;
            errors       = 0;
            checked      = 0;
            alloc_count  = 0;
            free_count   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int block_limit();
            if (total_blocks > TOTAL_MAX) return MAX_BLOCKS;
            return int'(total_blocks);
        endfunction

        function void note_request(logic func, logic [BLOCK_W-1:0] bn);
            grant_t g;
            int     lim;
            int     n;
            bit     found;
            lim     = block_limit();
            g.block = '0;
            g.status = ST_OK;
            if (func == FUNC_ALLOC) begin
                alloc_count++;
                found = 1'b0;
                n = 0;
                // first fit: lowest clear bit below the limit
                while (!found && n < lim) begin
                    if (!in_use[n]) begin
                        in_use[n] = 1'b1;
                        g.block   = n[BLOCK_W-1:0];
                        found     = 1'b1;
                    end
                    n++;
                end
                if (!found) g.status = ST_OUT_OF_BLOCKS;
            end else begin
                free_count++;
                if (int'(bn) >= lim) g.status = ST_OUT_OF_RANGE;
                else if (!in_use[bn]) g.status = ST_DOUBLE_FREE;
                else in_use[bn] = 1'b0;
            end
            status_seen[g.status]++;
            pending_grants.push_back(g);
        endfunction

        function void check_result(logic [BLOCK_W-1:0] block, logic [1:0] status);
            grant_t g;
            checked++;
            if (pending_grants.size() == 0) begin
                errors++;
                $display("%0t: unexpected result block=%0d status=%0d", $time, block, status);
                return;
            end
            g = pending_grants.pop_front();
            if (block !== g.block) begin
                errors++;
                $display("%0t: granted_block mismatch expected=%0d actual=%0d",
                         $time, g.block, block);
            end
            if (status !== g.status) begin
                errors++;
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, g.status, status);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_func = FUNC_ALLOC;
    logic [BLOCK_W-1:0] i_block_number = '0;
    logic               i_cfg_we = 1'b0;
    logic [TOTAL_W-1:0] i_cfg_wdata = '0;
    logic               o_done;
    logic [BLOCK_W-1:0] o_granted_block;
    logic [1:0]         o_status;

    alloc_scoreboard sb = new();
    int              idle_pct = 0;
    int              quiet_cycles = 0;
    int              cfg_writes = 0;

    bitmap_block_allocator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_block_number  (i_block_number),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_granted_block (o_granted_block),
        .o_status        (o_status)
    );

    always #6 i_clk = ~i_clk;

    // check the retiring item before noting a new one taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_result(o_granted_block, o_status);
            if (start && !busy) sb.note_request(i_func, i_block_number);
            if (i_cfg_we) begin
                sb.total_blocks = i_cfg_wdata;
                cfg_writes++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done || i_cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, sb.pending_grants.size());
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_request(input logic func, input logic [BLOCK_W-1:0] bn);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start          <= 1'b1;
        i_func         <= func;
        i_block_number <= bn;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [TOTAL_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_request();
        int lim;
        int span;
        lim = sb.block_limit();
        if ($urandom_range(99) < 50) begin
            send_request(FUNC_ALLOC, BLOCK_W'($urandom));
        end else if ($urandom_range(99) < 15) begin
            send_request(FUNC_FREE, BLOCK_W'($urandom));
        end else begin
            // aim frees at the region that holds granted blocks
            span = (lim > 300) ? 320 : lim + 4;
            send_request(FUNC_FREE, BLOCK_W'($urandom_range(span)));
        end
    endtask

    function automatic logic [TOTAL_W-1:0] phase_total(input int phase);
        case (phase)
            0: return TOTAL_W'($urandom_range(1, 40));
            1: return TOTAL_RESET;
            2: return TOTAL_W'($urandom_range(4097, 8191));
            3: return TOTAL_W'($urandom_range(41, 300));
            4: return TOTAL_W'(1);
            5: return TOTAL_W'($urandom_range(2, 12));
            6: return '0;
            default: return '1;
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first fit, double free, ignored block number on allocate
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, BLOCK_W'(1));
        send_request(FUNC_FREE, BLOCK_W'(1));
        send_request(FUNC_ALLOC, '1);
        send_request(FUNC_FREE, '1);
        send_request(FUNC_FREE, '0);
        // zero limit
        write_total('0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, '0);
        // lowered limit leaves block 2 stranded above it
        write_total(TOTAL_W'(2));
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, BLOCK_W'(2));
        send_request(FUNC_FREE, BLOCK_W'(1));
        // oversized limit
        write_total('1);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, '1);
        send_request(FUNC_FREE, BLOCK_W'(2));
        write_total(TOTAL_W'(4097));
        send_request(FUNC_FREE, '1);
        send_request(FUNC_ALLOC, '0);
        write_total(TOTAL_W'(1));
        send_request(FUNC_FREE, BLOCK_W'(1));
        send_request(FUNC_ALLOC, '0);

        for (int phase = 0; phase < PHASES; phase++) begin
            write_total(phase_total(phase));
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 74;
                default: idle_pct = 17;
            endcase
            repeat (PHASE_ITEMS) random_request();
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d allocates and %0d frees over %0d limit settings; %0d results checked.",
                 sb.alloc_count, sb.free_count, cfg_writes, sb.checked);
        $display("Status counts: ok %0d, out of blocks %0d, double free %0d, out of range %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_OUT_OF_BLOCKS],
                 sb.status_seen[ST_DOUBLE_FREE], sb.status_seen[ST_OUT_OF_RANGE]);
        if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bba_pkg.sv
rtl/bba_bitmap_ram.sv
rtl/bba_scan_unit.sv
rtl/bitmap_block_allocator.sv
rtl/bba_checker.sv
tb/tb.sv
